### hdl/nfha_pkg.sv
// Shared types and constants for the next-fit heap allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package nfha_pkg;

  localparam int unsigned HEAP_BYTES = 1024;
  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = AW + 2;
  localparam int unsigned EW = LW + 2;

  typedef struct packed {
    logic          mark;
    logic          used;
    logic [LW-1:0] len;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_FAIL,
    OP_A_START,
    OP_A_SEL,
    OP_A_EVAL,
    OP_A_SPLIT,
    OP_F_CHK,
    OP_F_SUCC,
    OP_F_ZSUCC,
    OP_F_WALK0,
    OP_F_WALK,
    OP_F_ZAT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_kind;
    logic size_zero;
    logic fit;
    logic exact;
    logic wrap_end;
    logic f_bad;
    logic succ_in;
    logic succ_free;
    logic at_zero;
    logic hit;
    logic prev_free;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### hdl/nfha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nfha_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hdl/nfha_ctrl.sv
// Sequencer for allocate, free and the clearing pass.
// Depends on nfha_pkg; drives the datapath by command, reads its status.
`default_nettype none
module nfha_ctrl
  import nfha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_AREAD  = 4'd2;
  localparam logic [3:0] S_ASEL   = 4'd3;
  localparam logic [3:0] S_AEVAL  = 4'd4;
  localparam logic [3:0] S_ASPLIT = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_FSUCC  = 4'd7;
  localparam logic [3:0] S_FZSUCC = 4'd8;
  localparam logic [3:0] S_FWALK0 = 4'd9;
  localparam logic [3:0] S_FWALK  = 4'd10;
  localparam logic [3:0] S_FZAT   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = sts_i.in_kind ? S_FCHK : S_AREAD;
        end
      end
      S_AREAD: begin
        if (sts_i.size_zero) begin
          cmd_o.op = OP_FAIL;
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_A_START;
          state_d = S_ASEL;
        end
      end
      S_ASEL: begin
        cmd_o.op = OP_A_SEL;
        state_d = S_AEVAL;
      end
      S_AEVAL: begin
        cmd_o.op = OP_A_EVAL;
        priority if (sts_i.fit) state_d = sts_i.exact ? S_OUT : S_ASPLIT;
        else if (sts_i.wrap_end) state_d = S_OUT;
        else state_d = S_AEVAL;
      end
      S_ASPLIT: begin
        cmd_o.op = OP_A_SPLIT;
        state_d = S_OUT;
      end
      S_FCHK: begin
        cmd_o.op = OP_F_CHK;
        priority if (sts_i.f_bad) state_d = S_OUT;
        else if (sts_i.succ_in) state_d = S_FSUCC;
        else state_d = S_FWALK0;
      end
      S_FSUCC: begin
        cmd_o.op = OP_F_SUCC;
        state_d = sts_i.succ_free ? S_FZSUCC : S_FWALK0;
      end
      S_FZSUCC: begin
        cmd_o.op = OP_F_ZSUCC;
        state_d = S_FWALK0;
      end
      S_FWALK0: begin
        cmd_o.op = OP_F_WALK0;
        state_d = sts_i.at_zero ? S_OUT : S_FWALK;
      end
      S_FWALK: begin
        cmd_o.op = OP_F_WALK;
        priority if (sts_i.hit && sts_i.prev_free) state_d = S_FZAT;
        else if (sts_i.hit || sts_i.walk_end) state_d = S_OUT;
        else state_d = S_FWALK;
      end
      S_FZAT: begin
        cmd_o.op = OP_F_ZAT;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.op = OP_OUT;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/nfha_dp.sv
// Datapath: block table RAM, cursor, walk registers and result register.
// Depends on nfha_pkg and nfha_ram; acts on commands from nfha_ctrl.
`default_nettype none
module nfha_dp
  import nfha_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cmd_t          cmd_i,
  output sts_t               sts_o,
  input  wire logic          in_kind_i,
  input  wire logic [10:0]   in_size_i,
  input  wire logic [AW-1:0] in_addr_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               out_ok_o,
  output logic [AW-1:0]      out_addr_o
);

  localparam logic [SW-1:0] HEAP_S = SW'(HEAP_BYTES);
  localparam logic [LW-1:0] HEAP_L = LW'(HEAP_BYTES);

  logic [LW-1:0] size_q, size_d, lat_q, lat_d;
  logic [AW-1:0] at_q, at_d, rover_q, rover_d, start_q, start_d, cur_q, cur_d;
  logic [AW-1:0] succ_q, succ_d, walk_q, walk_d, prev_q, prev_d, clr_q, clr_d;
  logic          res_ok_q, res_ok_d, out_valid_q, out_valid_d, out_ok_q, out_ok_d;
  logic [AW-1:0] res_addr_q, res_addr_d, out_addr_q, out_addr_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rd;
  logic [EW-1:0] rdata;

  logic [SW-1:0] cur_sum, at_sum, walk_sum;
  logic [AW-1:0] nxt, rest;

  nfha_ram #(.WIDTH(EW), .DEPTH(HEAP_BYTES)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd       = entry_t'(rdata);
  assign cur_sum  = {2'b00, cur_q} + {1'b0, rd.len};
  assign at_sum   = {2'b00, at_q} + {1'b0, rd.len};
  assign walk_sum = {2'b00, walk_q} + {1'b0, rd.len};
  assign nxt      = (cur_sum >= HEAP_S) ? '0 : cur_sum[AW-1:0];
  assign rest     = cur_q + size_q[AW-1:0];

  always_comb begin
    sts_o.clr_last  = (clr_q == {AW{1'b1}});
    sts_o.in_kind   = in_kind_i;
    sts_o.size_zero = (size_q == '0);
    sts_o.fit       = !rd.used && (rd.len >= size_q);
    sts_o.exact     = (rd.len == size_q);
    sts_o.wrap_end  = (nxt == start_q);
    sts_o.f_bad     = !rd.mark || !rd.used;
    sts_o.succ_in   = (at_sum < HEAP_S);
    sts_o.succ_free = rd.mark && !rd.used;
    sts_o.at_zero   = (at_q == '0);
    sts_o.hit       = (walk_sum == {2'b00, at_q});
    sts_o.prev_free = !rd.used;
    sts_o.walk_end  = (walk_sum >= HEAP_S) || (rd.len == '0);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    size_d = size_q; lat_d = lat_q; at_d = at_q; rover_d = rover_q;
    start_d = start_q; cur_d = cur_q; succ_d = succ_q; walk_d = walk_q;
    prev_d = prev_q; clr_d = clr_q; res_ok_d = res_ok_q; res_addr_d = res_addr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ok_d = out_ok_q; out_addr_d = out_addr_q;
    we = 1'b0; waddr = at_q; wdata = '0; raddr = at_q;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_CLR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata.mark = (clr_q == '0);
        wdata.len = (clr_q == '0) ? HEAP_L : '0;
        clr_d = clr_q + 1'b1;
      end
      OP_LOAD: begin
        size_d = in_size_i;
        at_d = in_addr_i;
        raddr = in_addr_i;
      end
      OP_FAIL: begin
        res_ok_d = 1'b0;
        res_addr_d = '0;
      end
      OP_A_START: raddr = rover_q;
      OP_A_SEL: begin
        start_d = rd.mark ? rover_q : '0;
        cur_d = start_d;
        raddr = start_d;
      end
      OP_A_EVAL: begin
        if (sts_o.fit) begin
          we = 1'b1;
          waddr = cur_q;
          wdata = '{mark: 1'b1, used: 1'b1, len: size_q};
          lat_d = rd.len - size_q;
          succ_d = rest;
          rover_d = sts_o.exact ? nxt : rest;
          res_ok_d = 1'b1;
          res_addr_d = cur_q;
        end else begin
          cur_d = nxt;
          raddr = nxt;
          res_ok_d = 1'b0;
          res_addr_d = '0;
        end
      end
      OP_A_SPLIT: begin
        we = 1'b1;
        waddr = succ_q;
        wdata = '{mark: 1'b1, used: 1'b0, len: lat_q};
      end
      OP_F_CHK: begin
        res_ok_d = 1'b0;
        res_addr_d = '0;
        lat_d = rd.len;
        succ_d = at_sum[AW-1:0];
        raddr = at_sum[AW-1:0];
        if (!sts_o.f_bad) begin
          we = 1'b1;
          wdata = '{mark: 1'b1, used: 1'b0, len: rd.len};
        end
      end
      OP_F_SUCC: begin
        if (sts_o.succ_free) begin
          lat_d = lat_q + rd.len;
          we = 1'b1;
          wdata = '{mark: 1'b1, used: 1'b0, len: lat_q + rd.len};
          if (rover_q == succ_q) rover_d = at_q;
        end
      end
      OP_F_ZSUCC: begin
        we = 1'b1;
        waddr = succ_q;
      end
      OP_F_WALK0: begin
        res_ok_d = 1'b1;
        res_addr_d = '0;
        walk_d = '0;
        raddr = '0;
      end
      OP_F_WALK: begin
        if (sts_o.hit) begin
          prev_d = walk_q;
          if (sts_o.prev_free) begin
            we = 1'b1;
            waddr = walk_q;
            wdata = '{mark: 1'b1, used: 1'b0, len: rd.len + lat_q};
          end
        end else begin
          walk_d = walk_sum[AW-1:0];
          raddr = walk_sum[AW-1:0];
        end
      end
      OP_F_ZAT: begin
        we = 1'b1;
        if (rover_q == at_q) rover_d = prev_q;
      end
      OP_OUT: begin
        if (sts_o.out_free) begin
          out_valid_d = 1'b1;
          out_ok_d = res_ok_q;
          out_addr_d = res_addr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= '0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rover_q <= rover_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d; lat_q <= lat_d; at_q <= at_d; start_q <= start_d;
    cur_q <= cur_d; succ_q <= succ_d; walk_q <= walk_d; prev_q <= prev_d;
    res_ok_q <= res_ok_d; res_addr_q <= res_addr_d;
    out_ok_q <= out_ok_d; out_addr_q <= out_addr_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o = out_ok_q;
  assign out_addr_o = out_addr_q;

endmodule
`default_nettype wire

### hdl/next_fit_heap_allocator.sv
// Top level of the next-fit heap allocator: stream ports, controller, datapath.
// Depends on nfha_pkg, nfha_ctrl, nfha_dp and nfha_ram.
//
// channel  dir  tdata                           tuser
// s_axis   in   [10:0] req_size, [20:11] free_addr  kind
// m_axis   out  [9:0] block_addr                   ok
//
// Allocate: load, read the rover, select the start, evaluate each block visited, split on
// a partial fit, then output; a zero size fails at once. Free: check the block (an ignored
// free goes straight out), merge a free successor, walk up to the freed one, merge a free
// predecessor, output. Reset clears all 1024 block table entries; no input is taken then.
// A stalled result holds in the output register; the next request is still taken.
`default_nettype none
module next_fit_heap_allocator
  import nfha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // req_size[10:0], free_addr[20:11], zero pad
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // block_addr[9:0], zero pad
  output logic             m_axis_tuser   // ok
);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] out_addr;

  nfha_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nfha_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (s_axis_tuser),
    .in_size_i   (s_axis_tdata[10:0]),
    .in_addr_i   (s_axis_tdata[20:11]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .out_addr_o  (out_addr)
  );

  assign m_axis_tdata = {{(16 - AW){1'b0}}, out_addr};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a request is in progress");
  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("failed result carries a nonzero address");
  a_load_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_LOAD |-> s_axis_tvalid && s_axis_tready)
    else $error("request loaded without a transfer");
`endif

endmodule
`default_nettype wire
